[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Sizes, operation and error codes, and the control word sent to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

    // queue size and word widths
    localparam int DEPTH       = 64;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int COUNT_OUT_W = 7;

    // reported top value when nothing is stored
    localparam logic signed [DATA_W-1:0] EMPTY_SENTINEL = -32'sd100000;

    // operation codes
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    // broadcast control for the cell row
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Holds one value; the row is kept in descending order, largest in slot 0.
// On push a cell keeps its value, takes the new item, or takes its left
// neighbor's value; on pop it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic                     occupied,
    input  logic signed [DATA_W-1:0] item,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic                     left_keep,
    input  logic signed [DATA_W-1:0] right_value,
    output logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] value_next,
    output logic                     keep
);

    logic signed [DATA_W-1:0] value_reg;

    // slot stays put on push when it holds a value not below the item
    assign keep = occupied && (value_reg >= item);

    // next slot content
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.push)
        begin
            if (keep)
                value_next = value_reg;
            else if (left_keep)
                value_next = item;
            else
                value_next = left_value;
        end
        else if (ctrl.pop)
        begin
            value_next = right_value;
        end
    end

    // slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[hw/rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: max-priority queue of signed 32-bit values
// A row of cells keeps the stored values sorted, largest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, operation, value): operation 0 pushes
//   value, operation 1 pops the largest entry.
//   Output channel (out_valid/out_ready): one result per input transfer with
//   the largest value afterwards (-100000 when empty), an empty flag, the
//   entry count and an error code (1 push when full, 2 pop when empty; the
//   stored contents are left unchanged in both cases).
//   Latency: the result is valid the cycle after the input transfer.
//   Throughput: one item per cycle. Every cell compares and shifts in the
//   same cycle, so a push or pop finishes in one pass through the row.
//   The single output register sets the pace: a new item is taken when the
//   register is empty or is being read in the same cycle.
//   Stall: while out_ready is low and a result waits, in_ready is low.
//   Reset: the queue is empty and no result is pending; cell contents are
//   not cleared, only slots below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] top_value,
    output logic                     empty_res,
    output logic [COUNT_OUT_W-1:0]   entry_count,
    output logic [1:0]               error
);

    logic                     in_xfer;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;
    err_t                     err_next;

    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic signed [DATA_W-1:0] cell_next  [DEPTH];
    logic                     cell_keep  [DEPTH];

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] top_value_reg;
    logic                     empty_res_reg;
    logic [CNT_W-1:0]         entry_count_reg;
    err_t                     error_reg;

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // decode operation and next count
    always_comb
    begin
        ctrl       = '0;
        err_next   = ERR_NONE;
        count_next = count_reg;
        case (op_t'(operation))
            OP_PUSH:
            begin
                if (full)
                    err_next = ERR_FULL;
                else
                begin
                    ctrl.push  = in_xfer;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (empty)
                    err_next = ERR_EMPTY;
                else
                begin
                    ctrl.pop   = in_xfer;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                err_next = ERR_NONE;
            end
        endcase
    end

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_value;
        logic                     left_keep;
        logic signed [DATA_W-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
            assign left_keep  = 1'b1;
        end
        else
        begin : g_mid
            assign left_value = cell_value[i-1];
            assign left_keep  = cell_keep[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(i) < count_reg),
            .item        (value),
            .left_value  (left_value),
            .left_keep   (left_keep),
            .right_value (right_value),
            .value       (cell_value[i]),
            .value_next  (cell_next[i]),
            .keep        (cell_keep[i])
        );
    end

    // count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                count_reg <= count_next;
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            top_value_reg   <= (count_next == '0) ? EMPTY_SENTINEL : cell_next[0];
            empty_res_reg   <= (count_next == '0);
            entry_count_reg <= count_next;
            error_reg       <= err_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = top_value_reg;
    assign empty_res   = empty_res_reg;
    assign entry_count = COUNT_OUT_W'(entry_count_reg);
    assign error       = error_reg;

endmodule

[sim/spq_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_result_checker: result predictor and scoreboard for the priority queue
// Watches both channels, keeps a shadow copy of the sorted contents, works
// out the result of every input transfer and compares each output transfer
// with the oldest waiting result, field by field.
// ----------------------------------------------------------------------------
module spq_result_checker
    import spq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] top_value,
    input  logic                     empty_res,
    input  logic [COUNT_OUT_W-1:0]   entry_count,
    input  logic [1:0]               error,
    output int                       fail_count,
    output int                       results_waiting,
    output int                       push_total,
    output int                       pop_total,
    output int                       full_rejects,
    output int                       empty_rejects
);

    // one predicted result
    typedef struct {
        logic signed [DATA_W-1:0] top;
        logic                     empty;
        logic [COUNT_OUT_W-1:0]   count;
        err_t                     err;
    } queue_result_t;

    logic signed [DATA_W-1:0] shadow_values[$];
    queue_result_t            expected_results[$];
    queue_result_t            oldest;
    int                       fails     = 0;
    int                       n_waiting = 0;
    int                       n_push    = 0;
    int                       n_pop     = 0;
    int                       n_full    = 0;
    int                       n_empty   = 0;

    assign fail_count      = fails;
    assign results_waiting = n_waiting;
    assign push_total      = n_push;
    assign pop_total       = n_pop;
    assign full_rejects    = n_full;
    assign empty_rejects   = n_empty;

    // apply one operation to the shadow contents and return what follows
    function automatic queue_result_t apply_queue_op(input op_t op,
                                                     input logic signed [DATA_W-1:0] v);
        queue_result_t r;
        int            slot;
        r.err = ERR_NONE;
        if (op == OP_PUSH)
        begin
            n_push++;
            if (shadow_values.size() >= DEPTH)
            begin
                r.err = ERR_FULL;
                n_full++;
            end
            else
            begin
                // equal values stay below the new one, which sits nearer the top at the back
                slot = shadow_values.size();
                while (slot > 0 && shadow_values[slot-1] > v)
                    slot--;
                shadow_values.insert(slot, v);
            end
        end
        else
        begin
            n_pop++;
            if (shadow_values.size() == 0)
            begin
                r.err = ERR_EMPTY;
                n_empty++;
            end
            else
                void'(shadow_values.pop_back());
        end
        r.empty = (shadow_values.size() == 0);
        r.top   = r.empty ? EMPTY_SENTINEL : shadow_values[shadow_values.size()-1];
        r.count = COUNT_OUT_W'(shadow_values.size());
        return r;
    endfunction

    // compare one field, x or z counts as a mismatch
    task automatic check_field(input string name, input logic signed [33:0] want,
                               input logic signed [33:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // score output transfers first, since a result never leaves in its own cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_values.delete();
            expected_results.delete();
            n_waiting = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, top %0d count %0d",
                             $time, top_value, entry_count);
                    fails++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("top_value", oldest.top, top_value);
                    check_field("empty_res", oldest.empty, empty_res);
                    check_field("entry_count", oldest.count, entry_count);
                    check_field("error", oldest.err, error);
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_queue_op(op_t'(operation), value));
            n_waiting = expected_results.size();
        end
    end

endmodule

[sim/sorted_priority_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb: stimulus and verdict for the priority queue
// Directed pushes and pops over the value extremes, the sentinel value and
// the empty queue, then random phases that fill, churn and drain the queue
// with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1030;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     operation;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] top_value;
    logic                     empty_res;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic [1:0]               error;

    int fail_count;
    int results_waiting;
    int push_total;
    int pop_total;
    int full_rejects;
    int empty_rejects;
    int items_sent = 0;
    int burst_left = 8;

    always #4 clk = ~clk;

    sorted_priority_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .top_value   (top_value),
        .empty_res   (empty_res),
        .entry_count (entry_count),
        .error       (error)
    );

    spq_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .top_value       (top_value),
        .empty_res       (empty_res),
        .entry_count     (entry_count),
        .error           (error),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .push_total      (push_total),
        .pop_total       (pop_total),
        .full_rejects    (full_rejects),
        .empty_rejects   (empty_rejects)
    );

    // one input transfer, then a random gap, possibly none, once the burst is used up
    task automatic issue(input op_t op, input logic signed [DATA_W-1:0] v);
        int gap;
        in_valid  <= 1'b1;
        operation <= op;
        value     <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // values: extremes, a narrow band for duplicates, near the sentinel, or anything
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
            1, 2: return DATA_W'($signed($urandom_range(0, 16)) - 8);
            3: return EMPTY_SENTINEL + DATA_W'($signed($urandom_range(0, 4)) - 2);
            default: return $urandom;
        endcase
    endfunction

    // output side stalls in stretches: always ready, coin flip, mostly stalled
    initial
    begin
        int mode;
        out_ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 80))
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int   phase;
        int   push_odds;
        op_t  op;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_PUSH;
        value     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, stored sentinel value, extremes and duplicates
        issue(OP_POP, 32'sd0);
        issue(OP_PUSH, 32'sd5);
        issue(OP_PUSH, EMPTY_SENTINEL);
        issue(OP_POP, 32'sd0);
        issue(OP_POP, 32'sh7fff_ffff);
        issue(OP_POP, 32'sd0);
        issue(OP_PUSH, 32'sh7fff_ffff);
        issue(OP_PUSH, 32'sh8000_0000);
        issue(OP_PUSH, 32'sd0);
        issue(OP_PUSH, -32'sd1);
        issue(OP_PUSH, 32'sd0);
        issue(OP_PUSH, 32'sh7fff_ffff);
        issue(OP_PUSH, 32'sh5555_5555);
        issue(OP_PUSH, 32'shaaaa_aaaa);
        repeat (9) issue(OP_POP, 32'sh5555_5555);

        // random phases: fill to full, churn, drain past empty
        phase = 0;
        while (items_sent < RANDOM_ITEMS + 23)
        begin
            case (phase % 3)
                0: push_odds = 15;
                1: push_odds = 8;
                default: push_odds = 1;
            endcase
            repeat ($urandom_range(90, 140))
            begin
                if (items_sent < RANDOM_ITEMS + 23)
                begin
                    op = ($urandom_range(0, 15) < push_odds) ? OP_PUSH : OP_POP;
                    issue(op, pick_value());
                end
            end
            phase++;
        end
        in_valid <= 1'b0;

        // let the scoreboard settle, drain the last results, then a few quiet cycles
        @(posedge clk);
        while (results_waiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d pushes and %0d pops in %0d transfers", push_total, pop_total,
                 items_sent);
        $display("pushes refused when full: %0d, pops refused when empty: %0d",
                 full_rejects, empty_rejects);
        if (fail_count == 0 && results_waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
sim/spq_result_checker.sv
sim/sorted_priority_queue_tb.sv
